// ===== design/chr_pkg.sv =====
package chr_pkg;

    // request and result payloads
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  name_byte;
        logic        final_byte;
        logic [30:0] key;
        logic [9:0]  hops;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] node_id;
        logic [6:0]  entry_count;
    } out_t;

    // modes
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_LOOKUP = 3'd2;
    localparam logic [2:0] MODE_AFTER  = 3'd3;
    localparam logic [2:0] MODE_BEFORE = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_SELF = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_RING_MODULUS = 2'd0;
    localparam logic [1:0] CFG_PROBE_STEP   = 2'd1;

    localparam logic [30:0] MODULUS_RESET = 31'd65536;
    localparam logic [30:0] STEP_RESET    = 31'd1;

    // one pjw hash step
    function automatic logic [31:0] pjw_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] n;
        logic [31:0] top;
        begin
            n   = {h[27:0], 4'd0} + {24'd0, b};
            top = n & 32'hF000_0000;
            if (top != 32'd0) begin
                n = (n ^ (top >> 24)) & 32'h0FFF_FFFF;
            end
            return n;
        end
    endfunction

endpackage

// ===== design/chr_div.sv =====
module chr_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);

    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvd_reg;
    logic [31:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    // one restoring step per cycle
    always_comb begin
        trial    = {rem_reg[31:0], dvd_reg[31]};
        rem_next = trial;
        if (trial >= {1'b0, dsr_reg}) begin
            rem_next = trial - {1'b0, dsr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[31:0];

endmodule

// ===== design/chr_ring_mem.sv =====
module chr_ring_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 31,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // synchronous write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/consistent_hash_ring_unit.sv =====
// sorted id ring held in one single-port-read memory, one request at a time
// add (non-final byte): hash update only; final byte: remainder of the hash, then a probe of
// every stored id with a new remainder per collision, then a shift of the larger entries
// remove / lookup: scan of the entries, plus a shift for remove; step modes add a remainder
// rate is set by the memory scans and the bit-serial remainder unit
// reset (synchronous, active low) empties the ring, clears the hash and restores config
module consistent_hash_ring_unit #(
    parameter int MAX_NODES = 64,
    parameter int ID_BITS   = 31
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  chr_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output chr_pkg::out_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [30:0]    cfg_data
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_HMOD, S_PROBE_RD, S_PROBE_CK, S_PROBE_MOD, S_SHIFT_RD, S_SHIFT_CK,
        S_SCAN_RD, S_SCAN_CK, S_DEL_RD, S_DEL_WR, S_TGT, S_HOPS, S_READ_T, S_READ_OUT,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [30:0]       modulus_reg;
    logic [30:0]       step_reg;
    logic [31:0]       hash_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     tries_reg;
    logic [CW-1:0]     s_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [30:0]       key_reg;
    logic [9:0]        hops_reg;
    logic [2:0]        mode_reg;
    logic [1:0]        res_status_reg;
    logic [30:0]       res_id_reg;
    logic              m_valid_reg;
    chr_pkg::out_t     m_data_reg;
    logic              div_start_reg;
    logic [31:0]       div_dvd_reg;
    logic [31:0]       div_dsr_reg;

    logic              div_done;
    logic [31:0]       div_rem;
    logic [AW-1:0]     rd_addr;
    logic [ID_BITS-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic [31:0]       id_space;
    logic [31:0]       hash_new;
    logic [CW:0]       tgt_sum;
    logic [CW-1:0]     tgt_idx;
    logic [CW-1:0]     hop_rem;
    logic [30:0]       rd_wide;

    chr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dsr_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    chr_ring_mem #(.DEPTH(MAX_NODES), .WIDTH(ID_BITS), .AW(AW)) u_mem (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // id space, capped at the id width
    always_comb begin
        id_space = {1'b0, modulus_reg};
        if (modulus_reg == 31'd0 || {1'b0, modulus_reg} > (32'd1 << ID_BITS)) begin
            id_space = 32'd1 << ID_BITS;
        end
    end

    assign hash_new = chr_pkg::pjw_step(hash_reg, s_data.name_byte);
    assign rd_wide  = 31'(rd_data);
    assign hop_rem  = div_rem[CW-1:0];

    // target index for the step modes
    always_comb begin
        if (mode_reg == chr_pkg::MODE_AFTER) begin
            tgt_sum = {1'b0, s_reg} + {1'b0, hop_rem};
        end else begin
            tgt_sum = {1'b0, s_reg} + {1'b0, count_reg} - {1'b0, hop_rem};
        end
        if (tgt_sum >= {1'b0, count_reg}) begin
            tgt_sum = tgt_sum - {1'b0, count_reg};
        end
        tgt_idx = tgt_sum[CW-1:0];
    end

    // memory read address
    always_comb begin
        unique case (state_reg)
            S_SHIFT_RD: rd_addr = AW'(idx_reg - CW'(1));
            S_DEL_RD:   rd_addr = AW'(idx_reg + CW'(1));
            S_READ_T:   rd_addr = s_reg[AW-1:0];
            default:    rd_addr = idx_reg[AW-1:0];
        endcase
    end

    // memory writes for insertion shift and deletion shift
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = id_reg;
        unique case (state_reg)
            S_SHIFT_RD: begin
                wr_en = (idx_reg == '0);
            end
            S_SHIFT_CK: begin
                wr_en = 1'b1;
                if (rd_data > id_reg) begin
                    wr_data = rd_data;
                end
            end
            S_DEL_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
            end
            default: ;
        endcase
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            modulus_reg   <= chr_pkg::MODULUS_RESET;
            step_reg      <= chr_pkg::STEP_RESET;
            hash_reg      <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == chr_pkg::CFG_RING_MODULUS) begin
                    modulus_reg <= cfg_data;
                end else if (cfg_index == chr_pkg::CFG_PROBE_STEP) begin
                    step_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg <= s_data.mode;
                        key_reg  <= s_data.key;
                        hops_reg <= s_data.hops;
                        idx_reg  <= '0;
                        if (s_data.mode == chr_pkg::MODE_ADD) begin
                            if (!s_data.final_byte) begin
                                hash_reg <= hash_new;
                            end else begin
                                hash_reg <= '0;
                                if (count_reg == CW'(MAX_NODES)) begin
                                    res_status_reg <= chr_pkg::ST_FULL;
                                    res_id_reg     <= '0;
                                    state_reg      <= S_OUT;
                                end else begin
                                    div_start_reg <= 1'b1;
                                    div_dvd_reg   <= hash_new;
                                    div_dsr_reg   <= id_space;
                                    tries_reg     <= '0;
                                    state_reg     <= S_HMOD;
                                end
                            end
                        end else if (s_data.mode == chr_pkg::MODE_REMOVE ||
                                     s_data.mode == chr_pkg::MODE_LOOKUP ||
                                     s_data.mode == chr_pkg::MODE_AFTER ||
                                     s_data.mode == chr_pkg::MODE_BEFORE) begin
                            if (count_reg == '0) begin
                                res_status_reg <= chr_pkg::ST_NONE;
                                res_id_reg     <= '0;
                                state_reg      <= S_OUT;
                            end else begin
                                state_reg <= S_SCAN_RD;
                            end
                        end
                    end
                end
                S_HMOD, S_PROBE_MOD: begin
                    if (div_done) begin
                        id_reg    <= div_rem[ID_BITS-1:0];
                        idx_reg   <= '0;
                        state_reg <= S_PROBE_RD;
                    end
                end
                // collision check against every stored id
                S_PROBE_RD: begin
                    if (idx_reg == count_reg) begin
                        state_reg <= S_SHIFT_RD;
                    end else begin
                        state_reg <= S_PROBE_CK;
                    end
                end
                S_PROBE_CK: begin
                    if (rd_data == id_reg) begin
                        if (tries_reg == count_reg) begin
                            res_status_reg <= chr_pkg::ST_FULL;
                            res_id_reg     <= '0;
                            state_reg      <= S_OUT;
                        end else begin
                            tries_reg     <= tries_reg + CW'(1);
                            div_start_reg <= 1'b1;
                            div_dvd_reg   <= 32'(id_reg) + {1'b0, step_reg};
                            div_dsr_reg   <= id_space;
                            state_reg     <= S_PROBE_MOD;
                        end
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_PROBE_RD;
                    end
                end
                // sorted insertion from the top down
                S_SHIFT_RD: begin
                    if (idx_reg == '0) begin
                        count_reg      <= count_reg + CW'(1);
                        res_status_reg <= chr_pkg::ST_OK;
                        res_id_reg     <= 31'(id_reg);
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_SHIFT_CK;
                    end
                end
                S_SHIFT_CK: begin
                    if (rd_data > id_reg) begin
                        idx_reg   <= idx_reg - CW'(1);
                        state_reg <= S_SHIFT_RD;
                    end else begin
                        count_reg      <= count_reg + CW'(1);
                        res_status_reg <= chr_pkg::ST_OK;
                        res_id_reg     <= 31'(id_reg);
                        state_reg      <= S_OUT;
                    end
                end
                // search for key match or successor
                S_SCAN_RD: begin
                    if (idx_reg == count_reg) begin
                        if (mode_reg == chr_pkg::MODE_REMOVE) begin
                            res_status_reg <= chr_pkg::ST_NONE;
                            res_id_reg     <= '0;
                            state_reg      <= S_OUT;
                        end else begin
                            s_reg     <= '0;
                            state_reg <= S_TGT;
                        end
                    end else begin
                        state_reg <= S_SCAN_CK;
                    end
                end
                S_SCAN_CK: begin
                    if (mode_reg == chr_pkg::MODE_REMOVE) begin
                        if (rd_wide == key_reg) begin
                            state_reg <= S_DEL_RD;
                        end else begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_SCAN_RD;
                        end
                    end else if (key_reg <= rd_wide) begin
                        s_reg     <= idx_reg;
                        state_reg <= S_TGT;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                // close the gap after removal
                S_DEL_RD: begin
                    if ({1'b0, idx_reg} + (CW+1)'(1) >= {1'b0, count_reg}) begin
                        count_reg      <= count_reg - CW'(1);
                        res_status_reg <= chr_pkg::ST_OK;
                        res_id_reg     <= key_reg;
                        state_reg      <= S_OUT;
                    end else begin
                        state_reg <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_DEL_RD;
                end
                S_TGT: begin
                    if (mode_reg == chr_pkg::MODE_LOOKUP) begin
                        state_reg <= S_READ_T;
                    end else begin
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= {22'd0, hops_reg};
                        div_dsr_reg   <= 32'(count_reg);
                        state_reg     <= S_HOPS;
                    end
                end
                S_HOPS: begin
                    if (div_done) begin
                        if (tgt_idx == s_reg) begin
                            res_status_reg <= chr_pkg::ST_SELF;
                            res_id_reg     <= '0;
                            state_reg      <= S_OUT;
                        end else begin
                            s_reg     <= tgt_idx;
                            state_reg <= S_READ_T;
                        end
                    end
                end
                S_READ_T: begin
                    state_reg <= S_READ_OUT;
                end
                S_READ_OUT: begin
                    res_status_reg <= chr_pkg::ST_OK;
                    res_id_reg     <= rd_wide;
                    state_reg      <= S_OUT;
                end
                // hand the result to the output register
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.status      <= res_status_reg;
                        m_data_reg.node_id     <= res_id_reg;
                        m_data_reg.entry_count <= 7'(count_reg);
                        state_reg              <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/sv/chr_checker.sv =====
`timescale 1ns / 100ps

module chr_checker #(
    parameter int MAX_NODES = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  chr_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  chr_pkg::out_t m_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_data,
    output int            fail_count,
    output int            pending
);

    // expected ring state
    logic [30:0] ring_model [MAX_NODES];
    int          ring_size;
    logic [31:0] name_hash;
    logic [30:0] modulus_reg;
    logic [30:0] step_reg;

    chr_pkg::out_t expected_results [$];

    assign pending = expected_results.size();

    function automatic chr_pkg::out_t make_result(logic [1:0] st, logic [30:0] id);
        chr_pkg::out_t r;
        r.status      = st;
        r.node_id     = (st == chr_pkg::ST_OK) ? id : 31'd0;
        r.entry_count = ring_size[6:0];
        return r;
    endfunction

    function automatic bit id_stored(logic [30:0] id);
        for (int i = 0; i < ring_size; i++) begin
            if (ring_model[i] == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    // hash the byte, probe and insert on the final byte
    function automatic bit hash_and_insert(chr_pkg::in_t req, output chr_pkg::out_t res);
        logic [31:0] h;
        logic [31:0] nib;
        longint      span;
        longint      id;
        bit          free;
        int          pos;
        h   = (name_hash << 4) + {24'd0, req.name_byte};
        nib = h & 32'hF000_0000;
        if (nib != 0) begin
            h = (h ^ (nib >> 24)) & 32'h0FFF_FFFF;
        end
        if (!req.final_byte) begin
            name_hash = h;
            return 1'b0;
        end
        name_hash = '0;
        if (ring_size >= MAX_NODES) begin
            res = make_result(chr_pkg::ST_FULL, '0);
            return 1'b1;
        end
        span = (modulus_reg == 0) ? 64'h8000_0000 : longint'(modulus_reg);
        id   = longint'(h) % span;
        free = 1'b0;
        for (int t = 0; t <= ring_size; t++) begin
            if (!id_stored(id[30:0])) begin
                free = 1'b1;
                break;
            end
            id = (id + longint'(step_reg)) % span;
        end
        if (!free) begin
            res = make_result(chr_pkg::ST_FULL, '0);
            return 1'b1;
        end
        pos = ring_size;
        for (int i = 0; i < ring_size; i++) begin
            if (id[30:0] < ring_model[i]) begin
                pos = i;
                break;
            end
        end
        for (int i = ring_size; i > pos; i--) ring_model[i] = ring_model[i-1];
        ring_model[pos] = id[30:0];
        ring_size++;
        res = make_result(chr_pkg::ST_OK, id[30:0]);
        return 1'b1;
    endfunction

    // next state and expected result of one request
    function automatic bit predict_ring_op(chr_pkg::in_t req, output chr_pkg::out_t res);
        int succ;
        int idx;
        int hop;
        int dest;
        if (req.mode == chr_pkg::MODE_ADD) return hash_and_insert(req, res);
        if (req.mode > chr_pkg::MODE_BEFORE) return 1'b0;
        if (ring_size == 0) begin
            res = make_result(chr_pkg::ST_NONE, '0);
            return 1'b1;
        end
        if (req.mode == chr_pkg::MODE_REMOVE) begin
            idx = ring_size;
            for (int i = 0; i < ring_size; i++) begin
                if (ring_model[i] == req.key) begin
                    idx = i;
                    break;
                end
            end
            if (idx == ring_size) begin
                res = make_result(chr_pkg::ST_NONE, '0);
                return 1'b1;
            end
            for (int i = idx; i + 1 < ring_size; i++) ring_model[i] = ring_model[i+1];
            ring_size--;
            res = make_result(chr_pkg::ST_OK, req.key);
            return 1'b1;
        end
        succ = 0;
        for (int i = 0; i < ring_size; i++) begin
            if (req.key <= ring_model[i]) begin
                succ = i;
                break;
            end
        end
        if (req.mode == chr_pkg::MODE_LOOKUP) begin
            res = make_result(chr_pkg::ST_OK, ring_model[succ]);
            return 1'b1;
        end
        hop = int'(req.hops) % ring_size;
        if (req.mode == chr_pkg::MODE_AFTER) dest = (succ + hop) % ring_size;
        else dest = (succ + ring_size - hop) % ring_size;
        if (dest == succ) res = make_result(chr_pkg::ST_SELF, '0);
        else res = make_result(chr_pkg::ST_OK, ring_model[dest]);
        return 1'b1;
    endfunction

    // watch all three channels
    always @(posedge aclk) begin
        chr_pkg::out_t res;
        chr_pkg::out_t want;
        if (!aresetn) begin
            fail_count  = 0;
            ring_size   = 0;
            name_hash   = '0;
            modulus_reg = chr_pkg::MODULUS_RESET;
            step_reg    = chr_pkg::STEP_RESET;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == chr_pkg::CFG_RING_MODULUS) modulus_reg = cfg_data;
                else if (cfg_index == chr_pkg::CFG_PROBE_STEP) step_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                if (predict_ring_op(s_data, res)) expected_results.push_back(res);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d id=%0d count=%0d", $time,
                             m_data.status, m_data.node_id, m_data.entry_count);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status != m_data.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_data.status);
                        fail_count++;
                    end
                    if (want.node_id != m_data.node_id) begin
                        $display("%0t: node_id expected %0d actual %0d", $time,
                                 want.node_id, m_data.node_id);
                        fail_count++;
                    end
                    if (want.entry_count != m_data.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d", $time,
                                 want.entry_count, m_data.entry_count);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_consistent_hash_ring_unit.sv =====
`timescale 1ns / 100ps

module tb_consistent_hash_ring_unit;

    localparam int CYCLE_LIMIT = 60_000_000;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    chr_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    chr_pkg::out_t m_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [30:0]   cfg_data;
    int            fail_count;
    int            pending;

    int          sender_idle;
    int          receiver_stall;
    bit          hold_off;
    logic [30:0] key_span;
    logic [30:0] seen_ids [$];
    longint      cycles;

    consistent_hash_ring_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    chr_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // timeout
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL consistent_hash_ring_unit");
                $finish;
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= receiver_stall);
        end
    end

    // ids that came back ok, used as keys for remove, lookup and the step modes
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.status == chr_pkg::ST_OK) begin
            seen_ids.push_back(m_data.node_id);
            if (seen_ids.size() > 200) void'(seen_ids.pop_front());
        end
    end

    task automatic send_req(chr_pkg::in_t req);
        while ($urandom_range(99) < sender_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic chr_pkg::in_t noise_req(logic [2:0] mode);
        chr_pkg::in_t r;
        logic [63:0]  bits;
        bits         = {$urandom, $urandom};
        r            = bits[$bits(chr_pkg::in_t)-1:0];
        r.mode       = mode;
        r.final_byte = 1'b0;
        return r;
    endfunction

    task automatic send_name(int len, int fixed_byte);
        chr_pkg::in_t r;
        for (int i = 0; i < len; i++) begin
            r = noise_req(chr_pkg::MODE_ADD);
            if (fixed_byte >= 0) r.name_byte = fixed_byte[7:0];
            r.final_byte = (i == len - 1);
            send_req(r);
        end
    endtask

    task automatic send_keyed(logic [2:0] mode, logic [30:0] key, logic [9:0] hops);
        chr_pkg::in_t r;
        r      = noise_req(mode);
        r.key  = key;
        r.hops = hops;
        send_req(r);
    endtask

    function automatic logic [30:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60 && seen_ids.size() > 0) begin
            return seen_ids[$urandom_range(seen_ids.size() - 1)];
        end
        if (sel < 85) return 31'($urandom_range(key_span));
        return 31'($urandom);
    endfunction

    // random mix; names dominate so the ring fills and gets drained
    task automatic random_requests(int n);
        int op;
        logic [9:0] hops;
        for (int k = 0; k < n; ) begin
            op   = $urandom_range(99);
            hops = ($urandom_range(1)) ? 10'($urandom_range(8)) : 10'($urandom);
            if (op < 40) begin
                op = $urandom_range(1, 5);
                send_name(op, ($urandom_range(9) == 0) ? 255 : -1);
                k += op;
            end else begin
                if (op < 58) send_keyed(chr_pkg::MODE_REMOVE, pick_key(), hops);
                else if (op < 72) send_keyed(chr_pkg::MODE_LOOKUP, pick_key(), hops);
                else if (op < 84) send_keyed(chr_pkg::MODE_AFTER, pick_key(), hops);
                else if (op < 96) send_keyed(chr_pkg::MODE_BEFORE, pick_key(), hops);
                else send_req(noise_req(3'($urandom_range(5, 7))));
                k++;
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic new_setting(logic [30:0] modulus, logic [30:0] step, int idle, int stall);
        settle();
        write_reg(chr_pkg::CFG_RING_MODULUS, modulus);
        write_reg(chr_pkg::CFG_PROBE_STEP, step);
        cfg_valid      <= 1'b0;
        key_span       = modulus;
        sender_idle    = idle;
        receiver_stall = stall;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        sender_idle    = 0;
        receiver_stall = 0;
        hold_off       = 1'b0;
        key_span       = chr_pkg::MODULUS_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty ring, unused modes, hash extremes, probing on a repeated name
        send_keyed(chr_pkg::MODE_LOOKUP, 31'd0, 10'd0);
        send_keyed(chr_pkg::MODE_REMOVE, 31'd5, 10'd0);
        send_keyed(chr_pkg::MODE_AFTER, 31'h7FFF_FFFF, 10'd1);
        send_keyed(chr_pkg::MODE_BEFORE, 31'd0, 10'd1023);
        send_req(noise_req(3'd5));
        send_req(noise_req(3'd7));
        send_name(8, 255);
        send_name(1, 0);
        send_name(1, 0);
        send_name(2, -1);
        send_keyed(chr_pkg::MODE_LOOKUP, 31'd0, 10'd0);
        send_keyed(chr_pkg::MODE_LOOKUP, 31'h7FFF_FFFF, 10'd0);
        send_keyed(chr_pkg::MODE_AFTER, 31'd1, 10'd0);
        send_keyed(chr_pkg::MODE_AFTER, 31'd1, 10'd1023);
        send_keyed(chr_pkg::MODE_BEFORE, 31'd1, 10'd1);
        send_keyed(chr_pkg::MODE_BEFORE, 31'd1, 10'd4);
        send_keyed(chr_pkg::MODE_REMOVE, 31'h7FFF_FFFF, 10'd0);
        settle();
        send_keyed(chr_pkg::MODE_REMOVE, seen_ids[$], 10'd0);

        // id space of one: the second add exhausts its probes
        new_setting(31'd1, 31'd1, 0, 0);
        send_name(1, 3);
        send_name(2, -1);
        random_requests(40);

        new_setting(31'd7, 31'd3, 88, 0);
        random_requests(150);

        // no idling, with a long receiver hold-off so the input backs up
        new_setting(31'd64, 31'd1, 0, 0);
        hold_off = 1'b1;
        random_requests(200);

        new_setting(31'h7FFF_FFFF, 31'h7FFF_FFFE, 0, 88);
        random_requests(150);

        new_setting(31'd100, 31'd7, 14, 14);
        random_requests(200);

        new_setting(31'd1000, 31'h4000_0001, 0, 0);
        random_requests(180);

        settle();
        if (fail_count == 0) begin
            $display("PASS consistent_hash_ring_unit");
        end else begin
            $display("FAIL consistent_hash_ring_unit");
        end
        $finish;
    end

endmodule
